>>> design/atcl_pkg.sv
// shared types, character constants and keyword tables for the at command line decoder
package atcl_pkg;

    // event codes on the result channel
    localparam logic [2:0] EV_NONE   = 3'd0;
    localparam logic [2:0] EV_TEMP   = 3'd1;
    localparam logic [2:0] EV_RESET  = 3'd2;
    localparam logic [2:0] EV_PREAD  = 3'd3;
    localparam logic [2:0] EV_PWRITE = 3'd4;
    localparam logic [2:0] EV_OK     = 3'd5;
    localparam logic [2:0] EV_ERROR  = 3'd6;
    localparam logic [2:0] EV_ISP    = 3'd7;

    // characters the decoder looks at
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_EQ   = 8'h3D;
    localparam logic [7:0] CH_A    = 8'h41;
    localparam logic [7:0] CH_T    = 8'h54;
    localparam logic [7:0] CH_PLUS = 8'h2B;

    // programming-mode sequence is eight characters long
    localparam int MAGIC_LEN = 8;
    localparam int MAGIC_W   = $clog2(MAGIC_LEN);

    // keyword indexes
    localparam int NUM_KW = 4;
    localparam logic [1:0] KW_TEMP = 2'd0;
    localparam logic [1:0] KW_RST  = 2'd1;
    localparam logic [1:0] KW_IAPR = 2'd2;
    localparam logic [1:0] KW_IAPW = 2'd3;

    // name length is tracked up to one past the longest keyword
    localparam int NAME_W = 3;
    localparam logic [NAME_W-1:0] NAME_SAT = 3'd5;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // one classified byte as handed from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       is_lf;
        logic       is_term;
        logic       isp;
    } item_t;

    // character of the programming-mode sequence at a position
    function automatic logic [7:0] magic_char(input logic [MAGIC_W-1:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0: c = 8'h40;    // '@'
            3'd1: c = 8'h53;    // 'S'
            3'd2: c = 8'h54;    // 'T'
            3'd3: c = 8'h43;    // 'C'
            3'd4: c = 8'h49;    // 'I'
            3'd5: c = 8'h53;    // 'S'
            3'd6: c = 8'h50;    // 'P'
            3'd7: c = 8'h23;    // '#'
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // length of each keyword
    function automatic logic [NAME_W-1:0] kw_len(input logic [1:0] kw);
        logic [NAME_W-1:0] n;
        unique case (kw)
            KW_RST:  n = 3'd3;
            default: n = 3'd4;
        endcase
        return n;
    endfunction

    // keyword characters, unused places hold zero
    function automatic logic [7:0] kw_char(input logic [1:0] kw, input logic [1:0] idx);
        logic [7:0] c;
        c = 8'h00;
        unique case (kw)
            KW_TEMP:
            begin
                unique case (idx)
                    2'd0: c = 8'h54;    // 'T'
                    2'd1: c = 8'h45;    // 'E'
                    2'd2: c = 8'h4D;    // 'M'
                    default: c = 8'h50; // 'P'
                endcase
            end
            KW_RST:
            begin
                unique case (idx)
                    2'd0: c = 8'h52;    // 'R'
                    2'd1: c = 8'h53;    // 'S'
                    2'd2: c = 8'h54;    // 'T'
                    default: c = 8'h00;
                endcase
            end
            KW_IAPR:
            begin
                unique case (idx)
                    2'd0: c = 8'h49;    // 'I'
                    2'd1: c = 8'h41;    // 'A'
                    2'd2: c = 8'h50;    // 'P'
                    default: c = 8'h52; // 'R'
                endcase
            end
            default:
            begin
                unique case (idx)
                    2'd0: c = 8'h49;    // 'I'
                    2'd1: c = 8'h41;    // 'A'
                    2'd2: c = 8'h50;    // 'P'
                    default: c = 8'h57; // 'W'
                endcase
            end
        endcase
        return c;
    endfunction

endpackage

>>> design/atcl_front.sv
// front end: takes received bytes, tracks the programming-mode sequence, classifies each byte
module atcl_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         rx_byte,
    input  logic               rx_valid,
    output logic               rx_ready,
    input  logic               q_full,
    output logic               q_push,
    output atcl_pkg::item_t    q_item
);

    logic [atcl_pkg::MAGIC_W-1:0] magic_pos_reg;
    logic [atcl_pkg::MAGIC_W-1:0] magic_pos_next;
    logic                         hit;
    logic                         isp;

    // accept whenever the queue has room
    assign rx_ready = !q_full;
    assign q_push   = rx_valid && !q_full;

    // sequence match, restarting on a mismatch
    always_comb
    begin
        hit = (rx_byte == atcl_pkg::magic_char(magic_pos_reg));
        isp = hit && (magic_pos_reg == atcl_pkg::MAGIC_W'(atcl_pkg::MAGIC_LEN - 1));
        if (hit)
        begin
            magic_pos_next = magic_pos_reg + atcl_pkg::MAGIC_W'(1);
        end
        else if (rx_byte == atcl_pkg::magic_char('0))
        begin
            magic_pos_next = atcl_pkg::MAGIC_W'(1);
        end
        else
        begin
            magic_pos_next = '0;
        end
    end

    // byte classification for the back end
    always_comb
    begin
        q_item.data    = rx_byte;
        q_item.is_lf   = (rx_byte == atcl_pkg::CH_LF);
        q_item.is_term = (rx_byte == atcl_pkg::CH_LF) || (rx_byte == atcl_pkg::CH_CR)
                         || (rx_byte == atcl_pkg::CH_EQ);
        q_item.isp     = isp;
    end

    // match position updates once per accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_pos_reg <= '0;
        end
        else if (q_push)
        begin
            magic_pos_reg <= magic_pos_next;
        end
    end

endmodule

>>> design/atcl_fifo.sv
// short queue of classified bytes between front and back
module atcl_fifo
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  atcl_pkg::item_t    push_item,
    output logic               full,
    input  logic               pop,
    output atcl_pkg::item_t    pop_item,
    output logic               empty
);

    atcl_pkg::item_t                 mem_reg [atcl_pkg::QUEUE_DEPTH];
    logic [atcl_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [atcl_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [atcl_pkg::QCNT_W-1:0]     count_reg;
    logic [atcl_pkg::QCNT_W-1:0]     count_next;

    assign full     = (count_reg == atcl_pkg::QCNT_W'(atcl_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = mem_reg[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + atcl_pkg::QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - atcl_pkg::QCNT_W'(1);
        end
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + atcl_pkg::QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + atcl_pkg::QPTR_W'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> design/atcl_back.sv
// back end: follows the line position by position and decodes it at a line feed
module atcl_back
#(
    parameter int LINE_DEPTH = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  atcl_pkg::item_t    q_item,
    output logic               q_pop,
    output logic [2:0]         event_res,
    output logic               event_valid,
    input  logic               event_ready
);

    localparam int POS_W = $clog2(LINE_DEPTH);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(LINE_DEPTH - 1);

    logic [POS_W-1:0]                    pos_reg;
    logic [POS_W-1:0]                    pos_next;
    logic                                a_ok_reg, a_ok_next;
    logic                                t_ok_reg, t_ok_next;
    logic                                plus_reg, plus_next;
    logic                                term_reg, term_next;
    logic [atcl_pkg::NAME_W-1:0]         len_reg, len_next;
    logic [atcl_pkg::NUM_KW-1:0]         kw_reg, kw_next;
    logic [atcl_pkg::NUM_KW-1:0]         kw_hit;
    logic [2:0]                          dec_ev;
    logic [2:0]                          ev;
    logic                                out_valid_reg;
    logic [2:0]                          event_reg;

    // take the next beat when the output register is free or draining
    assign q_pop       = !q_empty && (!out_valid_reg || event_ready);
    assign event_valid = out_valid_reg;
    assign event_res   = event_reg;

    // keyword hits on the name gathered so far
    always_comb
    begin
        for (int k = 0; k < atcl_pkg::NUM_KW; k++)
        begin
            kw_hit[k] = kw_reg[k] && (len_reg == atcl_pkg::kw_len(2'(k)));
        end
    end

    // line decode, valid when the current byte is a line feed
    always_comb
    begin
        dec_ev = atcl_pkg::EV_NONE;
        if (pos_reg < POS_W'(2))
        begin
            dec_ev = atcl_pkg::EV_NONE;
        end
        else if (!(a_ok_reg && t_ok_reg))
        begin
            dec_ev = atcl_pkg::EV_NONE;
        end
        else if (pos_reg == POS_W'(2) || !plus_reg)
        begin
            // third character is the line feed itself or is not '+'
            dec_ev = atcl_pkg::EV_OK;
        end
        else if (kw_hit[atcl_pkg::KW_TEMP])
        begin
            dec_ev = atcl_pkg::EV_TEMP;
        end
        else if (kw_hit[atcl_pkg::KW_RST])
        begin
            dec_ev = atcl_pkg::EV_RESET;
        end
        else if (kw_hit[atcl_pkg::KW_IAPR])
        begin
            dec_ev = atcl_pkg::EV_PREAD;
        end
        else if (kw_hit[atcl_pkg::KW_IAPW])
        begin
            dec_ev = atcl_pkg::EV_PWRITE;
        end
        else
        begin
            dec_ev = atcl_pkg::EV_ERROR;
        end
    end

    // event for this beat
    always_comb
    begin
        priority if (q_item.is_lf)
        begin
            ev = dec_ev;
        end
        else if (q_item.isp)
        begin
            ev = atcl_pkg::EV_ISP;
        end
        else
        begin
            ev = atcl_pkg::EV_NONE;
        end
    end

    // line tracking: position, prefix flags and name match
    always_comb
    begin
        pos_next  = pos_reg + POS_W'(1);
        a_ok_next = a_ok_reg;
        t_ok_next = t_ok_reg;
        plus_next = plus_reg;
        term_next = term_reg;
        len_next  = len_reg;
        kw_next   = kw_reg;
        if (q_item.is_lf || pos_reg == POS_LAST)
        begin
            // line feed clears the line, a wrap starts it over
            pos_next  = '0;
            a_ok_next = 1'b0;
            t_ok_next = 1'b0;
            plus_next = 1'b0;
            term_next = 1'b0;
            len_next  = '0;
            kw_next   = '1;
        end
        else if (pos_reg == POS_W'(0))
        begin
            a_ok_next = (q_item.data == atcl_pkg::CH_A);
        end
        else if (pos_reg == POS_W'(1))
        begin
            t_ok_next = (q_item.data == atcl_pkg::CH_T);
        end
        else if (pos_reg == POS_W'(2))
        begin
            plus_next = (q_item.data == atcl_pkg::CH_PLUS);
        end
        else if (!term_reg)
        begin
            if (q_item.is_term)
            begin
                term_next = 1'b1;
            end
            else
            begin
                if (len_reg != atcl_pkg::NAME_SAT)
                begin
                    len_next = len_reg + atcl_pkg::NAME_W'(1);
                end
                for (int k = 0; k < atcl_pkg::NUM_KW; k++)
                begin
                    kw_next[k] = kw_reg[k] && (len_reg < atcl_pkg::kw_len(2'(k)))
                                 && (q_item.data == atcl_pkg::kw_char(2'(k), len_reg[1:0]));
                end
            end
        end
    end

    // line state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            a_ok_reg      <= 1'b0;
            t_ok_reg      <= 1'b0;
            plus_reg      <= 1'b0;
            term_reg      <= 1'b0;
            len_reg       <= '0;
            kw_reg        <= '1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                pos_reg       <= pos_next;
                a_ok_reg      <= a_ok_next;
                t_ok_reg      <= t_ok_next;
                plus_reg      <= plus_next;
                term_reg      <= term_next;
                len_reg       <= len_next;
                kw_reg        <= kw_next;
                out_valid_reg <= 1'b1;
            end
            else if (event_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            event_reg <= ev;
        end
    end

endmodule

>>> design/at_command_line_decoder_unit.sv
// top level of the at command line decoder: front, queue and back
//
// channel   signals                          dir   payload
// rx        rx_valid / rx_ready              in    rx_byte    (8 bits)
// event     event_valid / event_ready        out   event_res  (3 bits)
//
// one byte a cycle sustained while event beats are taken; every byte gives exactly one event beat
// once its byte is taken, an event passes through the queue, then the output register
// a line feed is decoded from flags kept while the line arrives, no pass over a store
// rx_ready drops only when the two-entry queue is full behind a stalled event
// asynchronous active-low reset empties the queue and clears line and match state
module at_command_line_decoder_unit
#(
    parameter int LINE_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  rx_byte,
    input  logic        rx_valid,
    output logic        rx_ready,
    output logic [2:0]  event_res,
    output logic        event_valid,
    input  logic        event_ready
);

    atcl_pkg::item_t push_item;
    atcl_pkg::item_t pop_item;
    logic            push;
    logic            pop;
    logic            full;
    logic            empty;

    // byte intake and sequence watch
    atcl_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_byte  (rx_byte),
        .rx_valid (rx_valid),
        .rx_ready (rx_ready),
        .q_full   (full),
        .q_push   (push),
        .q_item   (push_item)
    );

    // decoupling queue
    atcl_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (empty)
    );

    // line decode and result register
    atcl_back #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (empty),
        .q_item      (pop_item),
        .q_pop       (pop),
        .event_res   (event_res),
        .event_valid (event_valid),
        .event_ready (event_ready)
    );

endmodule

>>> design/atcl_checker.sv
// port-level checks for the at command line decoder, bound to the top level
module atcl_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    input  logic        rx_ready,
    input  logic [2:0]  event_res,
    input  logic        event_valid,
    input  logic        event_ready
);

    logic [1:0] pend_reg;
    logic [1:0] pend_next;

    // bytes taken whose event beat has not gone out yet
    always_comb
    begin
        pend_next = pend_reg;
        if ((rx_valid && rx_ready) && !(event_valid && event_ready))
        begin
            pend_next = pend_reg + 2'd1;
        end
        else if (!(rx_valid && rx_ready) && (event_valid && event_ready))
        begin
            pend_next = pend_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // no event beat without a byte behind it
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg == 2'd0) |-> !event_valid)
        else $error("event beat with no pending byte");

    // with nothing pending the block takes a byte
    a_ready_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg == 2'd0) |-> rx_ready)
        else $error("byte refused while idle");

    // intake stops once queue and output register are full
    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg == 2'd3) |-> !rx_ready)
        else $error("byte taken beyond capacity");

    // a stalled event beat holds
    a_event_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (event_valid && !event_ready) |=> (event_valid && $stable(event_res)))
        else $error("stalled event beat changed");

endmodule

bind at_command_line_decoder_unit atcl_checker u_atcl_checker (.*);

>>> tb/tb_at_command_line_decoder_unit.sv
// self-checking testbench for the at command line decoder unit
module tb_at_command_line_decoder_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_DEPTH     = 16;
    localparam int RANDOM_BYTES   = 2000;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int HOLD_CYCLES    = 300;
    localparam int MAX_REPORTS    = 10;
    localparam int DRAIN_CYCLES   = 20;
    // programming-mode sequence, first character in the top byte
    localparam logic [8*atcl_pkg::MAGIC_LEN-1:0] ISP_SEQ = 64'h40_53_54_43_49_53_50_23;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic [7:0] rx_byte = 8'h00;
    logic       rx_valid = 1'b0;
    logic       rx_ready;
    logic [2:0] event_res;
    logic       event_valid;
    logic       event_ready = 1'b0;

    // stimulus backlog and predicted events
    logic [7:0] byte_backlog [$];
    logic [2:0] pending_events [$];
    int         total_bytes = 0;
    int         bytes_sent = 0;
    int         events_seen = 0;
    int         mismatches = 0;
    int         cycles = 0;
    int         hold_left = 0;
    bit         hold_done = 1'b0;

    // decoder state mirror
    logic [7:0] line_buf [LINE_DEPTH];
    int         wr_pos;
    int         seq_pos;

    at_command_line_decoder_unit #(
        .LINE_DEPTH (LINE_DEPTH)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx_byte     (rx_byte),
        .rx_valid    (rx_valid),
        .rx_ready    (rx_ready),
        .event_res   (event_res),
        .event_valid (event_valid),
        .event_ready (event_ready)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // ---------------------------------------------------------------- prediction

    function automatic logic [7:0] isp_char(input int idx);
        return ISP_SEQ[8*(atcl_pkg::MAGIC_LEN-1-idx) +: 8];
    endfunction

    function automatic string keyword_name(input logic [1:0] kw);
        string s;
        case (kw)
            atcl_pkg::KW_TEMP: s = "TEMP";
            atcl_pkg::KW_RST:  s = "RST";
            atcl_pkg::KW_IAPR: s = "IAPR";
            default: s = "IAPW";
        endcase
        return s;
    endfunction

    function automatic bit name_is(input int len, input string kw);
        bit same;
        int k;
        same = (len == kw.len());
        for (k = 0; k < kw.len() && same; k++)
            if (line_buf[3 + k] != kw[k])
                same = 1'b0;
        return same;
    endfunction

    // decode the n bytes of a finished line
    function automatic logic [2:0] line_event(input int n);
        int  term;
        int  i;
        bit  found;
        logic [2:0] ev;
        if (n < 3)
            return atcl_pkg::EV_NONE;
        if (line_buf[0] != atcl_pkg::CH_A || line_buf[1] != atcl_pkg::CH_T)
            return atcl_pkg::EV_NONE;
        if (line_buf[2] != atcl_pkg::CH_PLUS)
            return atcl_pkg::EV_OK;
        term = n - 1;
        found = 1'b0;
        for (i = 3; i < n; i++)
        begin
            if (!found && (line_buf[i] == atcl_pkg::CH_EQ || line_buf[i] == atcl_pkg::CH_CR
                           || line_buf[i] == atcl_pkg::CH_LF))
            begin
                term = i;
                found = 1'b1;
            end
        end
        ev = atcl_pkg::EV_ERROR;
        if (name_is(term - 3, keyword_name(atcl_pkg::KW_TEMP)))
            ev = atcl_pkg::EV_TEMP;
        else if (name_is(term - 3, keyword_name(atcl_pkg::KW_RST)))
            ev = atcl_pkg::EV_RESET;
        else if (name_is(term - 3, keyword_name(atcl_pkg::KW_IAPR)))
            ev = atcl_pkg::EV_PREAD;
        else if (name_is(term - 3, keyword_name(atcl_pkg::KW_IAPW)))
            ev = atcl_pkg::EV_PWRITE;
        return ev;
    endfunction

    function automatic void clear_line();
        int i;
        for (i = 0; i < LINE_DEPTH; i++)
            line_buf[i] = 8'h00;
        wr_pos = 0;
    endfunction

    // one received byte in, one event out
    function automatic logic [2:0] predict_event(input logic [7:0] b);
        logic [2:0] ev;
        int n;
        ev = atcl_pkg::EV_NONE;
        line_buf[wr_pos] = b;
        n = wr_pos + 1;
        wr_pos = n % LINE_DEPTH;

        // sequence tracking, a mismatching '@' starts over at one
        if (b == isp_char(seq_pos))
        begin
            seq_pos++;
            if (seq_pos == atcl_pkg::MAGIC_LEN)
            begin
                ev = atcl_pkg::EV_ISP;
                seq_pos = 0;
            end
        end
        else
            seq_pos = (b == isp_char(0)) ? 1 : 0;

        if (b == atcl_pkg::CH_LF)
        begin
            ev = line_event(n);
            clear_line();
        end
        return ev;
    endfunction

    // ---------------------------------------------------------------- stimulus

    task automatic push_byte(input logic [7:0] b);
        byte_backlog.push_back(b);
    endtask

    task automatic push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endtask

    function automatic logic [7:0] rand_upper();
        return 8'h41 + 8'($urandom_range(25));
    endfunction

    function automatic logic [7:0] rand_no_lf();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        while (b == atcl_pkg::CH_LF)
            b = 8'($urandom_range(255));
        return b;
    endfunction

    // sequence with an optional wrong character at bad_at
    task automatic push_isp_seq(input int bad_at);
        int i;
        for (i = 0; i < atcl_pkg::MAGIC_LEN; i++)
            push_byte((i == bad_at) ? rand_upper() : isp_char(i));
    endtask

    // "AT+" keyword, possibly damaged, with a random terminator
    task automatic add_command_line();
        string kw;
        int    mode;
        int    ch_at;
        int    i;
        int    n;
        kw = keyword_name(2'($urandom_range(atcl_pkg::NUM_KW - 1)));
        mode = $urandom_range(5);
        ch_at = $urandom_range(kw.len() - 1);
        push_text("AT+");
        for (i = 0; i < kw.len(); i++)
        begin
            if (mode == 1 && i == ch_at)
                push_byte(rand_upper());
            else if (mode != 0 || i != kw.len() - 1)
                push_byte(kw[i]);
        end
        if (mode == 2)
            push_byte(rand_upper());
        case ($urandom_range(2))
            0:
            begin
                push_byte(atcl_pkg::CH_EQ);
                n = $urandom_range(4);
                for (i = 0; i < n; i++)
                    push_byte(rand_no_lf());
            end
            1: push_byte(atcl_pkg::CH_CR);
            default: ;
        endcase
        push_byte(atcl_pkg::CH_LF);
    endtask

    task automatic add_random_line();
        int sel;
        int i;
        int n;
        sel = $urandom_range(99);
        if (sel < 45)
            add_command_line();
        else if (sel < 55)
        begin
            // plain AT with trailing junk
            push_text("AT");
            n = $urandom_range(6);
            for (i = 0; i < n; i++)
                push_byte(rand_no_lf());
            push_byte(atcl_pkg::CH_LF);
        end
        else if (sel < 65)
        begin
            // programming-mode sequence, whole or broken
            case ($urandom_range(3))
                0: push_isp_seq(-1);
                1: push_isp_seq($urandom_range(atcl_pkg::MAGIC_LEN - 1));
                2:
                begin
                    push_byte(isp_char(0));
                    push_isp_seq(-1);
                end
                default:
                begin
                    n = $urandom_range(atcl_pkg::MAGIC_LEN - 1);
                    for (i = 0; i < n; i++)
                        push_byte(isp_char(i));
                    push_isp_seq(-1);
                end
            endcase
        end
        else if (sel < 72)
        begin
            // overlong line so the store can wrap before or within the command
            n = $urandom_range(10, 30);
            for (i = 0; i < n; i++)
                push_byte(rand_no_lf());
            add_command_line();
        end
        else if (sel < 80)
        begin
            case ($urandom_range(4))
                0: push_text("\n");
                1: push_text("A\n");
                2: push_text("AT+\n");
                3: push_text("AT+=\n");
                default: push_text("AT\r\n");
            endcase
        end
        else
        begin
            // raw noise over the full byte range
            n = $urandom_range(1, 8);
            for (i = 0; i < n; i++)
                push_byte(8'($urandom_range(255)));
        end
    endtask

    // ---------------------------------------------------------------- idling

    function automatic int sender_idle_pct();
        if (bytes_sent < total_bytes / 3)
            return 27;
        else if (bytes_sent < 2 * total_bytes / 3)
            return 80;
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (events_seen < total_bytes / 3)
            return 80;
        else if (events_seen < 2 * total_bytes / 3)
            return 27;
        return 0;
    endfunction

    // ---------------------------------------------------------------- driver

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_valid <= 1'b0;
            rx_byte  <= 8'h00;
        end
        else
        begin
            // accepted beat updates the mirror
            if (rx_valid && rx_ready)
            begin
                pending_events.push_back(predict_event(rx_byte));
                bytes_sent++;
            end
            if (!rx_valid || rx_ready)
            begin
                if (byte_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct())
                begin
                    rx_byte  <= byte_backlog.pop_front();
                    rx_valid <= 1'b1;
                end
                else
                    rx_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- hold-off

    // one long receiver hold-off while the sender keeps going
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && total_bytes != 0 && events_seen >= 5 * total_bytes / 6)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // ---------------------------------------------------------------- monitor

    task automatic flag_mismatch(input string what, input logic [2:0] want,
                                 input logic [2:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%s at event %0d: expected %0d, got %0d",
                     what, events_seen, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            event_ready <= 1'b0;
        else
        begin
            if (event_valid && event_ready)
            begin
                if (pending_events.size() == 0)
                    flag_mismatch("unexpected event beat", atcl_pkg::EV_NONE, event_res);
                else if (event_res !== pending_events[0])
                    flag_mismatch("event_res mismatch", pending_events.pop_front(),
                                  event_res);
                else
                    void'(pending_events.pop_front());
                events_seen++;
            end

            if (hold_left > 0)
                event_ready <= 1'b0;
            else
                event_ready <= ($urandom_range(99) >= receiver_idle_pct());
        end
    end

    // ---------------------------------------------------------------- watchdog

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial
    begin
        seq_pos = 0;
        clear_line();

        // directed: byte extremes, ok, reset, empty name, sequence
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(atcl_pkg::CH_LF);
        push_text("AT\n");
        push_text("AT+RST\n");
        push_text("AT+\n");
        push_isp_seq(-1);

        while (byte_backlog.size() < RANDOM_BYTES + 25)
            add_random_line();
        total_bytes = byte_backlog.size();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (bytes_sent < total_bytes || pending_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending_events.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
